// ===== hw/rtl/bpoi_pkg.sv =====
package bpoi_pkg;

  localparam int VERTEX_W   = 32;
  localparam int RANK_W     = 16;
  localparam int PCOUNT_W   = 17;
  localparam int VOUT_W     = 33;
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 32;
  localparam int MUL_A_W    = 33;
  localparam int MUL_P_W    = MUL_A_W + PCOUNT_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [PCOUNT_W-1:0] MAX_RANKS = 17'd65536;

  localparam logic OP_LOCATE    = 1'b0;
  localparam logic OP_TO_GLOBAL = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_RANK_COUNT   = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [VERTEX_W-1:0] vertex_in;
    logic [RANK_W-1:0]   rank_in;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0] owner_rank;
    logic [VOUT_W-1:0] vertex_out;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_EST,
    ST_LOAD_EST,
    ST_WAIT_EST,
    ST_CLAMP,
    ST_MUL_START,
    ST_LOAD_START,
    ST_WAIT_START
  } state_t;

endpackage

// ===== hw/rtl/block_partition_owner_index.sv =====
// Block distribution translator: N vertices over P ranks, rank r starts at
// floor(r*N/P).
// Configuration: APB port, vertex_count at 0x0, rank_count at 0x4; write
// only while the block is idle. pready is tied high.
// Command channel: an item is taken at a clock edge with start high and busy
// low. operation selects locate (global vertex to owner and local index) or
// to-global (rank and local index to global vertex).
// Result: one word per item, shown on result for exactly one cycle with done
// high. The receiver cannot stall, so the word must be taken in that cycle.
// Each division runs 48 restoring steps, one quotient bit per cycle: locate
// needs two (one when vertex_count is zero), to-global one. busy drops in the
// done cycle, so the next item can be taken at the edge that ends it.
// One item is in flight at a time.
// The owner of a vertex is found as min(P-1, ((v+1)*P-1)/N), the largest
// rank whose start does not exceed v, then the start is subtracted.
// Reset (rst, synchronous) sets vertex_count and rank_count to one and
// returns the sequencer to idle; no word is in flight after reset.
module block_partition_owner_index
  import bpoi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              done,
  output result_t           result
);

  logic [VERTEX_W-1:0]   vertex_count;
  logic [PCOUNT_W-1:0]   rank_eff;
  logic [PCOUNT_W-1:0]   rank_last;

  state_t                state, state_next;
  item_t                 cur;
  logic [PCOUNT_W-1:0]   owner;
  logic [DIVIDEND_W-1:0] prod;
  logic [MUL_A_W-1:0]    mul_a;
  logic [PCOUNT_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]    mul_full;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  accept;

  bpoi_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count),
    .rank_eff     (rank_eff)
  );

  bpoi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign rank_last = rank_eff - PCOUNT_W'(1);
  assign busy      = (state != ST_IDLE);
  assign accept    = start & ~busy;

  // shared multiplier: (v+1)*P for the estimate, owner*N for the start
  always_comb begin
    if (state == ST_MUL_EST) begin
      mul_a = {1'b0, cur.vertex_in} + MUL_A_W'(1);
      mul_b = rank_eff;
    end else begin
      mul_a = {1'b0, vertex_count};
      mul_b = owner;
    end
  end
  assign mul_full = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = {{(DIVISOR_W-PCOUNT_W){1'b0}}, rank_eff};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (item.operation == OP_TO_GLOBAL) state_next = ST_MUL_START;
          else if (vertex_count == '0)                 state_next = ST_MUL_START;
          else                                         state_next = ST_MUL_EST;
        end
      end
      ST_MUL_EST:  state_next = ST_LOAD_EST;
      ST_LOAD_EST: begin
        div_start    = 1'b1;
        div_dividend = prod - DIVIDEND_W'(1);
        div_divisor  = vertex_count;
        state_next   = ST_WAIT_EST;
      end
      ST_WAIT_EST:   if (div_done) state_next = ST_CLAMP;
      ST_CLAMP:      state_next = ST_MUL_START;
      ST_MUL_START:  state_next = ST_LOAD_START;
      ST_LOAD_START: begin
        div_start  = 1'b1;
        state_next = ST_WAIT_START;
      end
      ST_WAIT_START: if (div_done) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_WAIT_START) && div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
      if (item.operation == OP_TO_GLOBAL) begin
        owner <= ({1'b0, item.rank_in} < rank_eff) ? {1'b0, item.rank_in} : rank_eff;
      end else begin
        owner <= rank_last;
      end
    end
    if (state == ST_MUL_EST || state == ST_MUL_START) begin
      prod <= mul_full[DIVIDEND_W-1:0];
    end
    if (state == ST_CLAMP) begin
      owner <= (quotient > {{(DIVIDEND_W-PCOUNT_W){1'b0}}, rank_last})
               ? rank_last : quotient[PCOUNT_W-1:0];
    end
    if (state == ST_WAIT_START && div_done) begin
      if (cur.operation == OP_TO_GLOBAL) begin
        result.owner_rank <= cur.rank_in;
        result.vertex_out <= {1'b0, quotient[VERTEX_W-1:0]} + {1'b0, cur.vertex_in};
      end else begin
        result.owner_rank <= owner[RANK_W-1:0];
        result.vertex_out <= {1'b0, cur.vertex_in} - {1'b0, quotient[VERTEX_W-1:0]};
      end
    end
  end

endmodule

// ===== hw/rtl/bpoi_regs.sv =====
module bpoi_regs
  import bpoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output logic [VERTEX_W-1:0]   vertex_count,
  output logic [PCOUNT_W-1:0]   rank_eff
);

  logic [PCOUNT_W-1:0] rank_count;
  logic                wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_W'(1);
      rank_count   <= PCOUNT_W'(1);
    end else if (wr) begin
      unique case (paddr[2])
        REG_VERTEX_COUNT: vertex_count <= pwdata;
        REG_RANK_COUNT:   rank_count   <= pwdata[PCOUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VERTEX_COUNT: prdata = vertex_count;
      REG_RANK_COUNT:   prdata = {{(DATA_W-PCOUNT_W){1'b0}}, rank_count};
      default:          prdata = '0;
    endcase
  end

  // zero counts as one rank, anything past the owner field saturates
  always_comb begin
    priority if (rank_count == '0)       rank_eff = PCOUNT_W'(1);
    else if (rank_count > MAX_RANKS)     rank_eff = MAX_RANKS;
    else                                 rank_eff = rank_count;
  end

endmodule

// ===== hw/rtl/bpoi_div.sv =====
module bpoi_div
  import bpoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [CNT_W-1:0]     count;
  logic                 running;
  logic [DIVISOR_W:0]   shifted;
  logic                 ge;

  // one restoring step per cycle: quotient bits shift in from the right
  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(DIVIDEND_W);
      end else if (running) begin
        if (count != '0) begin
          count <= count - CNT_W'(1);
        end else begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (running && count != '0) begin
      rem      <= ge ? DIVISOR_W'(shifted - {1'b0, dsr}) : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

// ===== verif/block_partition_owner_index_tb.sv =====
module block_partition_owner_index_tb;
  import bpoi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 225;

  // Expected words for the owner/local-index translator, oldest first.
  class partition_board;
    bit [31:0] vcount;
    bit [16:0] pcount;
    result_t   pending[$];
    int        errors;

    function new();
      vcount = 1;
      pcount = 1;
      errors = 0;
    endfunction

    function void set_register(logic idx, bit [31:0] value);
      if (idx == REG_VERTEX_COUNT) begin
        vcount = value;
      end else begin
        pcount = value[16:0];
      end
    endfunction

    // Zero ranks act as one, anything above the owner range saturates.
    function bit [63:0] ranks();
      bit [63:0] p;
      p = 64'(pcount);
      if (p == 0) p = 1;
      if (p > 64'(MAX_RANKS)) p = 64'(MAX_RANKS);
      return p;
    endfunction

    function bit [63:0] range_start(bit [63:0] r, bit [63:0] p);
      return (r * vcount) / p;
    endfunction

    function result_t translate(item_t it);
      bit [63:0] p, r, v, rr;
      result_t   w;
      p = ranks();
      v = 64'(it.vertex_in);
      if (it.operation == OP_LOCATE) begin
        if (vcount == 0) begin
          r = p - 1;
        end else begin
          r = (v * p) / vcount;
          if (r > p - 1) r = p - 1;
        end
        // step up while the next range still starts at or below the vertex
        while (r + 1 < p && range_start(r + 1, p) <= v) r++;
        w.owner_rank = r[15:0];
        w.vertex_out = 33'(v - range_start(r, p));
      end else begin
        rr = (it.rank_in < p) ? 64'(it.rank_in) : p;
        w.owner_rank = it.rank_in;
        w.vertex_out = 33'(range_start(rr, p) + v);
      end
      return w;
    endfunction

    function void log_item(item_t it);
      pending = {pending, translate(it)};
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: owner %0d vertex %0d", got.owner_rank, got.vertex_out);
        return;
      end
      want = pending.pop_front();
      if (got.owner_rank !== want.owner_rank || got.vertex_out !== want.vertex_out) begin
        errors++;
        if (errors <= 10)
          $display("word mismatch: owner exp %0d got %0d, vertex exp %0d got %0d",
                   want.owner_rank, got.owner_rank, want.vertex_out, got.vertex_out);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              start;
  logic              busy;
  item_t             item;
  logic              done;
  result_t           result;

  partition_board board;
  int             quiet_cycles = 0;

  block_partition_owner_index dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic cfg_write(logic idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic send_item(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    board.log_item(it);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic item_t edge_item(int k);
    item_t     it;
    bit [63:0] p;
    p  = board.ranks();
    it = '0;
    case (k)
      0: begin
        it.operation = OP_LOCATE;
        it.rank_in   = 16'hFFFF;
      end
      1: begin
        it.operation = OP_LOCATE;
        it.vertex_in = board.vcount - 32'd1;
      end
      2: begin
        it.operation = OP_LOCATE;
        it.vertex_in = 32'hFFFF_FFFF;
      end
      3: begin
        it.operation = OP_TO_GLOBAL;
        it.rank_in   = 16'hFFFF;
        it.vertex_in = 32'hFFFF_FFFF;
      end
      default: begin
        it.operation = OP_TO_GLOBAL;
        it.rank_in   = 16'(p - 1);
      end
    endcase
    return it;
  endfunction

  function automatic item_t random_item();
    item_t     it;
    bit [63:0] p, s;
    p = board.ranks();
    it.operation = 1'($urandom_range(1));
    it.rank_in   = 16'($urandom);
    it.vertex_in = $urandom;
    if (it.operation == OP_LOCATE) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          // land on, just below or just above a range boundary
          s = board.range_start(64'($urandom_range(32'(p - 1))), p);
          it.vertex_in = 32'(s) + 32'($urandom_range(2)) - 32'd1;
        end
        5, 6: if (board.vcount != 0) it.vertex_in = $urandom_range(board.vcount - 32'd1);
        7: if (board.vcount != 32'hFFFF_FFFF)
          it.vertex_in = $urandom_range(board.vcount, 32'hFFFF_FFFF);
        default: ;
      endcase
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: it.rank_in = 16'($urandom_range(32'(p - 1)));
        6, 7: if (p < 65536) it.rank_in = 16'($urandom_range(32'(p), 65535));
        default: ;
      endcase
      if ($urandom_range(1)) it.vertex_in = $urandom_range(32'(board.range_start(1, p)));
    end
    return it;
  endfunction

  initial begin
    int        cfg, k, ph, idle;
    bit [31:0] n;
    board   = new();
    rst     <= 1'b1;
    start   <= 1'b0;
    item    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // edge values under the reset setting and a few corner settings
    for (cfg = 0; cfg < 5; cfg++) begin
      drain();
      case (cfg)
        1: begin
          cfg_write(REG_VERTEX_COUNT, 32'd10);
          cfg_write(REG_RANK_COUNT, 32'd3);
        end
        2: begin
          cfg_write(REG_VERTEX_COUNT, 32'd0);
          cfg_write(REG_RANK_COUNT, 32'd5);
        end
        3: begin
          cfg_write(REG_VERTEX_COUNT, 32'd7);
          cfg_write(REG_RANK_COUNT, 32'd0);
        end
        4: begin
          cfg_write(REG_VERTEX_COUNT, 32'hFFFF_FFFF);
          cfg_write(REG_RANK_COUNT, 32'h0001_FFFF);
        end
        default: ;
      endcase
      for (k = 0; k < 5; k++) send_item(edge_item(k));
    end

    for (ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(REG_VERTEX_COUNT, 32'hFFFF_FFFF);
          cfg_write(REG_RANK_COUNT, 32'd65536);
        end
        1: begin
          cfg_write(REG_VERTEX_COUNT, 32'd0);
          cfg_write(REG_RANK_COUNT, 32'hFFFF_FFFF);
        end
        2: begin
          cfg_write(REG_VERTEX_COUNT, 32'd1);
          cfg_write(REG_RANK_COUNT, 32'd0);
        end
        3: begin
          cfg_write(REG_VERTEX_COUNT, $urandom_range(1, 1000));
          cfg_write(REG_RANK_COUNT, $urandom_range(1, 64));
        end
        4: begin
          cfg_write(REG_VERTEX_COUNT, $urandom);
          cfg_write(REG_RANK_COUNT, $urandom_range(1, 65536));
        end
        5: begin
          // at least as many ranks as vertices: empty ranges once there are more
          n = $urandom_range(1, 5000);
          cfg_write(REG_VERTEX_COUNT, n);
          cfg_write(REG_RANK_COUNT, $urandom_range(n, 65536));
        end
        6: begin
          cfg_write(REG_VERTEX_COUNT, $urandom);
          cfg_write(REG_RANK_COUNT, $urandom_range(2, 300));
        end
        default: begin
          cfg_write(REG_VERTEX_COUNT, 32'hFFFF_FFFF);
          cfg_write(REG_RANK_COUNT, 32'd1);
        end
      endcase
      case (ph % 4)
        1: idle = 57;
        3: idle = 23;
        default: idle = 0;
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item());
        if (k == 100) begin
          drain();
        end else if ($urandom_range(99) < idle) begin
          hold_off($urandom_range(1, 130));
        end
      end
    end

    drain();
    repeat (120) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // check each word and watch for a stalled handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) board.check_word(result);
      if (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
